// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// Types, codes and cost helpers of the grid A* path search unit.
// ----------------------------------------------------------------------------
package gasp_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	localparam int COORD_W = 6;
	localparam int CRD_W   = 8;
	localparam int DIM_W   = 9;
	localparam int REG_W   = 7;
	localparam int G_W     = 32;
	localparam int H_W     = 21;
	localparam int COST_W  = 16;

	localparam logic [7:0] STEP_DIAG     = 8'd141;
	localparam logic [7:0] STEP_STRAIGHT = 8'd100;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] STAT_LOADED  = 2'd0;
	localparam logic [1:0] STAT_GOAL    = 2'd1;
	localparam logic [1:0] STAT_NEAREST = 2'd2;
	localparam logic [1:0] STAT_PATH    = 2'd3;

	localparam logic [1:0] NODE_UNSEEN = 2'd0;
	localparam logic [1:0] NODE_OPEN   = 2'd1;
	localparam logic [1:0] NODE_CLOSED = 2'd2;

	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CRD_W-1:0]   crd_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [G_W-1:0]     cost_t;
	typedef logic [H_W-1:0]     heur_t;

	typedef struct packed {
		logic [1:0] action;
		coord_t     cell_x;
		coord_t     cell_y;
		logic       passable;
		logic [7:0] slow_factor;
		coord_t     goal_x;
		coord_t     goal_y;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       step_valid;
		coord_t     step_x;
		coord_t     step_y;
		logic       last;
	} rsp_t;

	typedef struct packed {
		dim_t w;
		dim_t h;
	} dims_t;

	function automatic heur_t octile(crd_t x, crd_t y, crd_t gx, crd_t gy);
		crd_t        dx;
		crd_t        dy;
		crd_t        lo;
		crd_t        hi;
		logic [16:0] s;
		dx = (x > gx) ? x - gx : gx - x;
		dy = (y > gy) ? y - gy : gy - y;
		lo = (dx < dy) ? dx : dy;
		hi = (dx < dy) ? dy : dx;
		s  = 17'(lo) * 17'(STEP_DIAG) + 17'(hi - lo) * 17'(STEP_STRAIGHT);
		return {s, 4'b0000};
	endfunction

	function automatic cost_t sat_add(cost_t a, cost_t b);
		logic [G_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[G_W] ? '1 : s[G_W-1:0];
	endfunction

	function automatic logic dir_left(logic [2:0] d);
		return (d == 3'd0) || (d == 3'd3) || (d == 3'd5);
	endfunction

	function automatic logic dir_right(logic [2:0] d);
		return (d == 3'd2) || (d == 3'd4) || (d == 3'd7);
	endfunction

	function automatic logic dir_up(logic [2:0] d);
		return (d == 3'd0) || (d == 3'd1) || (d == 3'd2);
	endfunction

	function automatic logic dir_down(logic [2:0] d);
		return (d == 3'd5) || (d == 3'd6) || (d == 3'd7);
	endfunction

endpackage

// ===== rtl/core/gasp_cfg.sv =====
// ----------------------------------------------------------------------------
// gasp_cfg
// APB register file for map width and height, with clamped dimensions.
// ----------------------------------------------------------------------------
module gasp_cfg #(
	parameter int MAX_WIDTH  = gasp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gasp_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output gasp_pkg::dims_t   dims
);

	logic [gasp_pkg::REG_W-1:0] width_q;
	logic [gasp_pkg::REG_W-1:0] height_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (wr_en) begin
			unique case (paddr[2])
				gasp_pkg::REG_MAP_WIDTH:  width_q  <= pwdata[gasp_pkg::REG_W-1:0];
				gasp_pkg::REG_MAP_HEIGHT: height_q <= pwdata[gasp_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == gasp_pkg::REG_MAP_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_comb begin
		dims.w = gasp_pkg::dim_t'(width_q);
		dims.h = gasp_pkg::dim_t'(height_q);
		if (width_q == '0)
			dims.w = 9'd1;
		else if (32'(width_q) > MAX_WIDTH)
			dims.w = gasp_pkg::dim_t'(MAX_WIDTH);
		if (height_q == '0)
			dims.h = 9'd1;
		else if (32'(height_q) > MAX_HEIGHT)
			dims.h = gasp_pkg::dim_t'(MAX_HEIGHT);
	end

endmodule

// ===== rtl/core/grid_astar_path_search_unit.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// 8-connected A* search over a loaded grid, binary min-heap open list.
// ----------------------------------------------------------------------------
// After reset the unit is busy while it clears the cell map. A load beat is
// taken every cycle while the unit is idle, and its result strobes the cycle
// after. A path read with steps left passes through S_PATH, which forms the
// step from the registered read of the parent-direction memory. A search
// first clears node status, then pops the open list with a sift-down and
// expands each neighbor, sifting new or improved nodes up, all through
// memories with one write and one read port each under one sequencer; busy
// stays high meanwhile. Every result shows on rsp for exactly one cycle with
// rsp_valid high and cannot be held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_astar_path_search_unit #(
	parameter int MAX_WIDTH  = gasp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gasp_pkg::DEF_MAX_HEIGHT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            start,
	output logic            busy,
	input  gasp_pkg::req_t  req,
	output logic            rsp_valid,
	output gasp_pkg::rsp_t  rsp
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int HPW   = AW + 1;

	typedef logic [AW-1:0]  idx_t;
	typedef logic [HPW-1:0] hp_t;
	typedef logic [HPW:0]   hpx_t;
	typedef logic [XW-1:0]  xc_t;
	typedef logic [YW-1:0]  yc_t;

	typedef enum logic [4:0] {
		S_CLR_MAP, S_IDLE, S_PATH, S_CLR_NODE, S_INIT, S_POP_CHK,
		S_POP1, S_POP2, S_POP3, S_POP4, S_SD_A, S_SD_B, S_SD_C, S_SD_D, S_SD_END,
		S_CLOSE1, S_CLOSE2, S_NB_A, S_NB_B, S_NB_C, S_NB_D, S_NB_E, S_NB_F,
		S_SU_A, S_SU_B, S_SU_C, S_SU_END, S_NEXT
	} state_t;

	gasp_pkg::dims_t dims;

	gasp_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .dims(dims)
	);

	// memories
	logic [8:0]            cmap_mem [DEPTH];
	logic [1:0]            nstat_mem [DEPTH];
	logic [2:0]            ndir_mem [DEPTH];
	gasp_pkg::cost_t       ng_mem [DEPTH];
	gasp_pkg::cost_t       nf_mem [DEPTH];
	idx_t                  hslot_mem [DEPTH+1];
	hp_t                   hpos_mem [DEPTH];

	logic                  cmap_we, nstat_we, node_we, heap_we;
	idx_t                  cmap_wa, cmap_ra, nstat_wa, node_wa, ng_ra, nf_ra, ndir_ra, hpos_ra;
	logic [8:0]            cmap_wd, cmap_rd;
	logic [1:0]            nstat_wd, nstat_rd;
	logic [2:0]            ndir_wd, ndir_rd;
	gasp_pkg::cost_t       ng_wd, nf_wd, ng_rd, nf_rd;
	hp_t                   hw_pos, hslot_ra, hpos_rd;
	idx_t                  hw_node, hslot_rd;

	always_ff @(posedge clk) begin
		if (cmap_we)
			cmap_mem[cmap_wa] <= cmap_wd;
		cmap_rd <= cmap_mem[cmap_ra];
	end

	always_ff @(posedge clk) begin
		if (nstat_we)
			nstat_mem[nstat_wa] <= nstat_wd;
		nstat_rd <= nstat_mem[node_wa];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			ndir_mem[node_wa] <= ndir_wd;
			ng_mem[node_wa]   <= ng_wd;
			nf_mem[node_wa]   <= nf_wd;
		end
		ndir_rd <= ndir_mem[ndir_ra];
		ng_rd   <= ng_mem[ng_ra];
		nf_rd   <= nf_mem[nf_ra];
	end

	always_ff @(posedge clk) begin
		if (heap_we) begin
			hslot_mem[hw_pos]  <= hw_node;
			hpos_mem[hw_node]  <= hw_pos;
		end
		hslot_rd <= hslot_mem[hslot_ra];
		hpos_rd  <= hpos_mem[hpos_ra];
	end

	// sequencer registers
	state_t                state_q;
	idx_t                  clr_q, start_idx_q, first_q, last_q, cl_q, cr_q, par_q;
	idx_t                  su_node_q, path_idx_q, best_idx_q;
	gasp_pkg::coord_t      gx_q, gy_q;
	hp_t                   cnt_q, u_q, m_q;
	gasp_pkg::cost_t       fl_q, fcl_q, ft_q, gn_q, ngt_q, gt_q;
	logic [1:0]            nst_q;
	logic [2:0]            d_q;
	gasp_pkg::heur_t       best_h_q;
	logic                  have_best_q, su_init_q, path_valid_q;
	logic                  rsp_valid_q;
	gasp_pkg::rsp_t        rsp_q;

	// neighbor geometry
	xc_t                   nx, tx, sx_n, px;
	yc_t                   ny, ty, sy_n, py;
	logic                  mv_l, mv_r, mv_u, mv_d, diag, inb;
	idx_t                  t_idx, p_idx;
	gasp_pkg::heur_t       nh_n, nh_t, nh_s;
	gasp_pkg::cost_t       step_cost, nf_new;
	gasp_pkg::dim_t        sx_c, sy_c;

	assign nx   = first_q[XW-1:0];
	assign ny   = first_q[AW-1:XW];
	assign mv_l = gasp_pkg::dir_left(d_q);
	assign mv_r = gasp_pkg::dir_right(d_q);
	assign mv_u = gasp_pkg::dir_up(d_q);
	assign mv_d = gasp_pkg::dir_down(d_q);
	assign diag = (mv_l || mv_r) && (mv_u || mv_d);
	assign tx   = mv_l ? nx - 1'b1 : (mv_r ? nx + 1'b1 : nx);
	assign ty   = mv_u ? ny - 1'b1 : (mv_d ? ny + 1'b1 : ny);
	assign t_idx = {ty, tx};
	assign inb  = !(mv_l && nx == '0) && !(mv_u && ny == '0)
		&& !(mv_r && (gasp_pkg::dim_t'(nx) + 9'd1 >= dims.w))
		&& !(mv_d && (gasp_pkg::dim_t'(ny) + 9'd1 >= dims.h));

	assign nh_n = gasp_pkg::octile(gasp_pkg::crd_t'(nx), gasp_pkg::crd_t'(ny),
		gasp_pkg::crd_t'(gx_q), gasp_pkg::crd_t'(gy_q));
	assign nh_t = gasp_pkg::octile(gasp_pkg::crd_t'(tx), gasp_pkg::crd_t'(ty),
		gasp_pkg::crd_t'(gx_q), gasp_pkg::crd_t'(gy_q));
	assign sx_n = start_idx_q[XW-1:0];
	assign sy_n = start_idx_q[AW-1:XW];
	assign nh_s = gasp_pkg::octile(gasp_pkg::crd_t'(sx_n), gasp_pkg::crd_t'(sy_n),
		gasp_pkg::crd_t'(gx_q), gasp_pkg::crd_t'(gy_q));

	assign step_cost = gasp_pkg::cost_t'(16'(cmap_rd[7:0])
		* 16'(diag ? gasp_pkg::STEP_DIAG : gasp_pkg::STEP_STRAIGHT));
	assign nf_new = gasp_pkg::sat_add(ngt_q, gasp_pkg::cost_t'(nh_t));

	assign sx_c = (gasp_pkg::dim_t'(req.cell_x) >= dims.w) ? dims.w - 9'd1
		: gasp_pkg::dim_t'(req.cell_x);
	assign sy_c = (gasp_pkg::dim_t'(req.cell_y) >= dims.h) ? dims.h - 9'd1
		: gasp_pkg::dim_t'(req.cell_y);

	// path walk-back
	xc_t pxx;
	yc_t pyy;
	assign pxx = path_idx_q[XW-1:0];
	assign pyy = path_idx_q[AW-1:XW];
	assign px  = gasp_pkg::dir_right(ndir_rd) ? ((pxx == '0) ? '0 : pxx - 1'b1)
		: (gasp_pkg::dir_left(ndir_rd) ? pxx + 1'b1 : pxx);
	assign py  = gasp_pkg::dir_down(ndir_rd) ? ((pyy == '0) ? '0 : pyy - 1'b1)
		: (gasp_pkg::dir_up(ndir_rd) ? pyy + 1'b1 : pyy);
	assign p_idx = {py, px};

	// sift-down selection
	hpx_t            two_u, two_u1, cnt_x;
	logic            has_l, has_r, sel_l, sel_r;
	gasp_pkg::cost_t fv;

	assign two_u  = {u_q, 1'b0};
	assign two_u1 = two_u + 1'b1;
	assign cnt_x  = hpx_t'(cnt_q);
	assign has_l  = two_u <= cnt_x;
	assign has_r  = two_u1 <= cnt_x;
	assign sel_l  = fl_q >= fcl_q;
	assign fv     = sel_l ? fcl_q : fl_q;
	assign sel_r  = has_r && (fv >= nf_rd);

	logic load_ok;
	assign load_ok = (32'(req.cell_x) < MAX_WIDTH) && (32'(req.cell_y) < MAX_HEIGHT);

	// memory ports
	always_comb begin
		cmap_we  = 1'b0;
		cmap_wa  = clr_q;
		cmap_wd  = '0;
		cmap_ra  = t_idx;
		nstat_we = 1'b0;
		nstat_wa = t_idx;
		nstat_wd = gasp_pkg::NODE_OPEN;
		node_we  = 1'b0;
		node_wa  = t_idx;
		ndir_wd  = d_q;
		ng_wd    = ngt_q;
		nf_wd    = nf_new;
		ng_ra    = t_idx;
		nf_ra    = hslot_rd;
		ndir_ra  = path_idx_q;
		hpos_ra  = t_idx;
		heap_we  = 1'b0;
		hw_pos   = u_q;
		hw_node  = last_q;
		hslot_ra = hp_t'(1);
		unique case (state_q)
			S_CLR_MAP: begin
				cmap_we = 1'b1;
			end
			S_IDLE: begin
				cmap_we = start && req.action == gasp_pkg::ACT_LOAD && load_ok;
				cmap_wa = {yc_t'(req.cell_y), xc_t'(req.cell_x)};
				cmap_wd = {req.passable, req.slow_factor};
			end
			S_CLR_NODE: begin
				nstat_we = 1'b1;
				nstat_wa = clr_q;
				nstat_wd = gasp_pkg::NODE_UNSEEN;
			end
			S_INIT: begin
				nstat_we = 1'b1;
				nstat_wa = start_idx_q;
				node_we  = 1'b1;
				node_wa  = start_idx_q;
				ndir_wd  = '0;
				ng_wd    = '0;
				nf_wd    = gasp_pkg::cost_t'(nh_s);
			end
			S_POP2: hslot_ra = cnt_q;
			S_SD_A: hslot_ra = hp_t'(two_u);
			S_SD_B: hslot_ra = hp_t'(two_u1);
			S_SD_D: begin
				heap_we = sel_l || sel_r;
				hw_node = sel_r ? cr_q : cl_q;
			end
			S_SD_END: heap_we = 1'b1;
			S_CLOSE1: begin
				nstat_we = 1'b1;
				nstat_wa = first_q;
				nstat_wd = gasp_pkg::NODE_CLOSED;
				ng_ra    = first_q;
			end
			S_NB_A: cmap_ra = diag ? {ty, nx} : t_idx;
			S_NB_B: cmap_ra = {ny, tx};
			S_NB_E: begin
				if (nst_q == gasp_pkg::NODE_UNSEEN) begin
					nstat_we = 1'b1;
					node_we  = 1'b1;
				end else if (nst_q == gasp_pkg::NODE_OPEN && ngt_q < gt_q) begin
					node_we = 1'b1;
				end
			end
			S_SU_A: hslot_ra = m_q >> 1;
			S_SU_C: begin
				heap_we = ft_q <= nf_rd;
				hw_pos  = m_q;
				hw_node = par_q;
			end
			S_SU_END: begin
				heap_we = 1'b1;
				hw_pos  = m_q;
				hw_node = su_node_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR_MAP;
			clr_q        <= '0;
			start_idx_q  <= '0;
			first_q      <= '0;
			last_q       <= '0;
			cl_q         <= '0;
			cr_q         <= '0;
			par_q        <= '0;
			su_node_q    <= '0;
			path_idx_q   <= '0;
			best_idx_q   <= '0;
			gx_q         <= '0;
			gy_q         <= '0;
			cnt_q        <= '0;
			u_q          <= '0;
			m_q          <= '0;
			fl_q         <= '0;
			fcl_q        <= '0;
			ft_q         <= '0;
			gn_q         <= '0;
			ngt_q        <= '0;
			gt_q         <= '0;
			nst_q        <= '0;
			d_q          <= '0;
			best_h_q     <= '0;
			have_best_q  <= 1'b0;
			su_init_q    <= 1'b0;
			path_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR_MAP: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						priority case (req.action)
							gasp_pkg::ACT_LOAD: begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= '0;
							end
							gasp_pkg::ACT_SEARCH: begin
								start_idx_q <= {yc_t'(sy_c), xc_t'(sx_c)};
								gx_q        <= req.goal_x;
								gy_q        <= req.goal_y;
								state_q     <= S_CLR_NODE;
							end
							gasp_pkg::ACT_READ: begin
								if (path_valid_q && path_idx_q != start_idx_q) begin
									state_q <= S_PATH;
								end else begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= '{status: gasp_pkg::STAT_PATH,
										step_valid: 1'b0, step_x: '0, step_y: '0,
										last: 1'b1};
								end
							end
							default: ;
						endcase
					end
				end
				S_PATH: begin
					rsp_valid_q      <= 1'b1;
					rsp_q.status     <= gasp_pkg::STAT_PATH;
					rsp_q.step_valid <= 1'b1;
					rsp_q.step_x     <= gasp_pkg::coord_t'(pxx);
					rsp_q.step_y     <= gasp_pkg::coord_t'(pyy);
					rsp_q.last       <= p_idx == start_idx_q;
					path_idx_q       <= p_idx;
					state_q          <= S_IDLE;
				end
				S_CLR_NODE: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_INIT;
				end
				S_INIT: begin
					cnt_q       <= hp_t'(1);
					m_q         <= hp_t'(1);
					su_node_q   <= start_idx_q;
					ft_q        <= gasp_pkg::cost_t'(nh_s);
					su_init_q   <= 1'b1;
					have_best_q <= 1'b0;
					state_q     <= S_SU_A;
				end
				S_POP_CHK: begin
					if (cnt_q == '0) begin
						rsp_valid_q  <= 1'b1;
						rsp_q        <= '{status: gasp_pkg::STAT_NEAREST,
							step_valid: 1'b0, step_x: '0, step_y: '0, last: 1'b0};
						path_idx_q   <= best_idx_q;
						path_valid_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_POP1;
					end
				end
				S_POP1: state_q <= S_POP2;
				S_POP2: begin
					first_q <= hslot_rd;
					state_q <= S_POP3;
				end
				S_POP3: begin
					last_q  <= hslot_rd;
					state_q <= S_POP4;
				end
				S_POP4: begin
					fl_q    <= nf_rd;
					cnt_q   <= cnt_q - 1'b1;
					u_q     <= hp_t'(1);
					state_q <= S_SD_A;
				end
				S_SD_A: state_q <= has_l ? S_SD_B : S_SD_END;
				S_SD_B: begin
					cl_q    <= hslot_rd;
					state_q <= S_SD_C;
				end
				S_SD_C: begin
					fcl_q   <= nf_rd;
					cr_q    <= hslot_rd;
					state_q <= S_SD_D;
				end
				S_SD_D: begin
					if (sel_r) begin
						u_q     <= hp_t'(two_u1);
						state_q <= S_SD_A;
					end else if (sel_l) begin
						u_q     <= hp_t'(two_u);
						state_q <= S_SD_A;
					end else begin
						state_q <= S_SD_END;
					end
				end
				S_SD_END: state_q <= S_CLOSE1;
				S_CLOSE1: begin
					if (!have_best_q || nh_n <= best_h_q) begin
						best_idx_q  <= first_q;
						best_h_q    <= nh_n;
						have_best_q <= 1'b1;
					end
					if (gasp_pkg::crd_t'(nx) == gasp_pkg::crd_t'(gx_q)
						&& gasp_pkg::crd_t'(ny) == gasp_pkg::crd_t'(gy_q)) begin
						rsp_valid_q  <= 1'b1;
						rsp_q        <= '{status: gasp_pkg::STAT_GOAL,
							step_valid: 1'b0, step_x: '0, step_y: '0, last: 1'b0};
						path_idx_q   <= first_q;
						path_valid_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_CLOSE2;
					end
				end
				S_CLOSE2: begin
					gn_q    <= ng_rd;
					d_q     <= '0;
					state_q <= S_NB_A;
				end
				S_NB_A: begin
					priority if (!inb)
						state_q <= S_NEXT;
					else if (diag)
						state_q <= S_NB_B;
					else
						state_q <= S_NB_D;
				end
				S_NB_B: state_q <= cmap_rd[8] ? S_NB_C : S_NEXT;
				S_NB_C: state_q <= cmap_rd[8] ? S_NB_D : S_NEXT;
				S_NB_D: begin
					if (cmap_rd[8]) begin
						ngt_q   <= gasp_pkg::sat_add(gn_q, step_cost);
						nst_q   <= nstat_rd;
						gt_q    <= ng_rd;
						state_q <= S_NB_E;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NB_E: begin
					ft_q      <= nf_new;
					su_node_q <= t_idx;
					su_init_q <= 1'b0;
					priority if (nst_q == gasp_pkg::NODE_UNSEEN) begin
						cnt_q   <= cnt_q + 1'b1;
						m_q     <= cnt_q + 1'b1;
						state_q <= S_SU_A;
					end else if (nst_q == gasp_pkg::NODE_OPEN && ngt_q < gt_q) begin
						state_q <= S_NB_F;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NB_F: begin
					m_q     <= hpos_rd;
					state_q <= S_SU_A;
				end
				S_SU_A: state_q <= (m_q > hp_t'(1)) ? S_SU_B : S_SU_END;
				S_SU_B: begin
					par_q   <= hslot_rd;
					state_q <= S_SU_C;
				end
				S_SU_C: begin
					if (ft_q <= nf_rd) begin
						m_q     <= m_q >> 1;
						state_q <= S_SU_A;
					end else begin
						state_q <= S_SU_END;
					end
				end
				S_SU_END: state_q <= su_init_q ? S_POP_CHK : S_NEXT;
				S_NEXT: begin
					if (d_q == 3'd7) begin
						state_q <= S_POP_CHK;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= S_NB_A;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEXT(a_load_ack, start && !busy && req.action == gasp_pkg::ACT_LOAD, rsp_valid && rsp.status == gasp_pkg::STAT_LOADED)
	`ASSERT_IMPLIES(a_empty_read_last, rsp_valid && rsp.status == gasp_pkg::STAT_PATH && !rsp.step_valid, rsp.last)
	`ASSERT_IMPLIES(a_heap_bound, state_q != S_CLR_MAP, hpx_t'(cnt_q) <= hpx_t'(DEPTH))
	`ASSERT_NEXT(a_search_busy, start && !busy && req.action == gasp_pkg::ACT_SEARCH, busy && !rsp_valid)

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid A* path search unit.
// ----------------------------------------------------------------------------
// Map sizes and cells are loaded through the APB port and the request beats.
// Searches and path reads follow. A behavioral copy of the search predicts
// every response, and each response strobe is checked field by field in
// arrival order. Directed cases come first, then random phases: size setup,
// cell loads, one or two searches, and a path read-back to its end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import gasp_pkg::*;

	localparam int GRID_W    = 64;
	localparam int GRID_H    = 64;
	localparam int CELLS     = GRID_W * GRID_H;
	localparam int LIMIT     = 20000000;
	localparam int ITEM_GOAL = 1000;
	localparam int EXP_DEPTH = 16;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [2:0] ADDR_WIDTH  = {REG_MAP_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_HEIGHT = {REG_MAP_HEIGHT, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	req_t        req;
	logic        rsp_valid;
	rsp_t        rsp;

	grid_astar_path_search_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req(req),
		.rsp_valid(rsp_valid), .rsp(rsp)
	);

	// predicted state
	int          NBR_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
	int          NBR_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
	logic [6:0]  cols_reg;
	logic [6:0]  rows_reg;
	logic [8:0]  cell_mem [CELLS];
	logic [1:0]  visit [CELLS];
	logic [2:0]  came_from [CELLS];
	logic [31:0] g_cost [CELLS];
	logic [31:0] f_key [CELLS];
	int          open_heap [CELLS+1];
	int          open_pos [CELLS];
	int          open_count;
	int          nearest_idx;
	logic [31:0] nearest_h;
	int          trace_idx;
	bit          trace_ok;
	int          origin_idx;

	rsp_t        exp_fifo [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;
	int          fails;
	int          cycles;
	int          beats;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid) begin
			if (exp_wr == exp_rd) begin
				$error("unexpected response status %0d", rsp.status);
				fails++;
			end else begin
				want = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (rsp.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, rsp.status);
					fails++;
				end
				if (rsp.step_valid !== want.step_valid) begin
					$error("step_valid exp %0d got %0d", want.step_valid, rsp.step_valid);
					fails++;
				end
				if (rsp.step_x !== want.step_x) begin
					$error("step_x exp %0d got %0d", want.step_x, rsp.step_x);
					fails++;
				end
				if (rsp.step_y !== want.step_y) begin
					$error("step_y exp %0d got %0d", want.step_y, rsp.step_y);
					fails++;
				end
				if (rsp.last !== want.last) begin
					$error("last exp %0d got %0d", want.last, rsp.last);
					fails++;
				end
			end
		end
	end

	function automatic logic [31:0] octile_h(int x, int y, int gx, int gy);
		int dx;
		int dy;
		int lo;
		int hi;
		dx = x > gx ? x - gx : gx - x;
		dy = y > gy ? y - gy : gy - y;
		lo = dx < dy ? dx : dy;
		hi = dx < dy ? dy : dx;
		return 32'(16 * (141 * lo + 100 * (hi - lo)));
	endfunction

	function automatic logic [31:0] add_sat(logic [31:0] a, longint unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic bit walkable(int x, int y);
		return cell_mem[y * GRID_W + x][8];
	endfunction

	function automatic void heap_exchange(int a, int b);
		int t;
		t = open_heap[a];
		open_heap[a] = open_heap[b];
		open_heap[b] = t;
		open_pos[open_heap[a]] = a;
		open_pos[open_heap[b]] = b;
	endfunction

	function automatic void heap_raise(int m);
		while (m > 1 && f_key[open_heap[m]] <= f_key[open_heap[m >> 1]]) begin
			heap_exchange(m, m >> 1);
			m = m >> 1;
		end
	endfunction

	function automatic void heap_insert(int idx);
		open_count++;
		open_heap[open_count] = idx;
		open_pos[idx] = open_count;
		heap_raise(open_count);
	endfunction

	function automatic int heap_take();
		int first;
		int u;
		int v;
		first = open_heap[1];
		v = 1;
		open_heap[1] = open_heap[open_count];
		open_pos[open_heap[1]] = 1;
		open_count--;
		forever begin
			u = v;
			if (2 * u + 1 <= open_count) begin
				if (f_key[open_heap[u]] >= f_key[open_heap[2 * u]])
					v = 2 * u;
				if (f_key[open_heap[v]] >= f_key[open_heap[2 * u + 1]])
					v = 2 * u + 1;
			end else if (2 * u <= open_count) begin
				if (f_key[open_heap[u]] >= f_key[open_heap[2 * u]])
					v = 2 * u;
			end
			if (u == v)
				break;
			heap_exchange(u, v);
		end
		return first;
	endfunction

	function automatic int clamp_dim(int v);
		if (v < 1)
			return 1;
		return v > GRID_W ? GRID_W : v;
	endfunction

	function automatic logic [1:0] astar_search(int sx, int sy, int gx, int gy);
		int          w;
		int          h;
		int          s;
		int          n;
		int          nx;
		int          ny;
		int          tx;
		int          ty;
		int          t;
		bit          diag;
		bit          have_best;
		logic [31:0] nh;
		logic [31:0] ng;
		w = clamp_dim(cols_reg);
		h = clamp_dim(rows_reg);
		have_best = 0;
		foreach (visit[i])
			visit[i] = NODE_UNSEEN;
		open_count = 0;
		if (sx >= w) sx = w - 1;
		if (sy >= h) sy = h - 1;
		s = sy * GRID_W + sx;
		origin_idx = s;
		g_cost[s] = 0;
		f_key[s] = octile_h(sx, sy, gx, gy);
		came_from[s] = 0;
		visit[s] = NODE_OPEN;
		heap_insert(s);
		while (open_count > 0) begin
			n = heap_take();
			nx = n % GRID_W;
			ny = n / GRID_W;
			nh = octile_h(nx, ny, gx, gy);
			visit[n] = NODE_CLOSED;
			if (!have_best || nh <= nearest_h) begin
				nearest_idx = n;
				nearest_h = nh;
				have_best = 1;
			end
			if (nx == gx && ny == gy) begin
				trace_idx = n;
				trace_ok = 1;
				return STAT_GOAL;
			end
			for (int d = 0; d < 8; d++) begin
				tx = nx + NBR_DX[d];
				ty = ny + NBR_DY[d];
				diag = NBR_DX[d] != 0 && NBR_DY[d] != 0;
				if (tx < 0 || tx >= w || ty < 0 || ty >= h)
					continue;
				if (diag && (!walkable(nx, ty) || !walkable(tx, ny)))
					continue;
				if (!walkable(tx, ty))
					continue;
				t = ty * GRID_W + tx;
				ng = add_sat(g_cost[n],
					longint'(diag ? 141 : 100) * longint'(cell_mem[t][7:0]));
				if (visit[t] == NODE_OPEN) begin
					if (ng < g_cost[t]) begin
						g_cost[t] = ng;
						came_from[t] = 3'(d);
						f_key[t] = add_sat(ng, octile_h(tx, ty, gx, gy));
						heap_raise(open_pos[t]);
					end
				end else if (visit[t] == NODE_UNSEEN) begin
					g_cost[t] = ng;
					came_from[t] = 3'(d);
					f_key[t] = add_sat(ng, octile_h(tx, ty, gx, gy));
					visit[t] = NODE_OPEN;
					heap_insert(t);
				end
			end
		end
		trace_idx = nearest_idx;
		trace_ok = 1;
		return STAT_NEAREST;
	endfunction

	function automatic rsp_t grid_response(req_t r);
		rsp_t o;
		int   x;
		int   y;
		int   px;
		int   py;
		o = '0;
		case (r.action)
			ACT_LOAD: begin
				cell_mem[int'(r.cell_y) * GRID_W + int'(r.cell_x)] = {r.passable, r.slow_factor};
				o.status = STAT_LOADED;
			end
			ACT_SEARCH: begin
				o.status = astar_search(r.cell_x, r.cell_y, r.goal_x, r.goal_y);
			end
			default: begin
				o.status = STAT_PATH;
				if (trace_ok && trace_idx != origin_idx) begin
					x = trace_idx % GRID_W;
					y = trace_idx / GRID_W;
					px = x - NBR_DX[came_from[trace_idx]];
					py = y - NBR_DY[came_from[trace_idx]];
					if (px < 0) px = 0;
					if (py < 0) py = 0;
					trace_idx = (py * GRID_W + px) % CELLS;
					o.step_valid = 1'b1;
					o.step_x = coord_t'(x);
					o.step_y = coord_t'(y);
					o.last = trace_idx == origin_idx;
				end else begin
					o.last = 1'b1;
				end
			end
		endcase
		return o;
	endfunction

	task automatic send_beat(input req_t r, output rsp_t predicted);
		if (!calm && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predicted = '0;
		if (r.action != ACT_NONE) begin
			predicted = grid_response(r);
			exp_fifo[exp_wr % EXP_DEPTH] = predicted;
			exp_wr++;
			beats++;
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_size(input logic [2:0] addr, input logic [6:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WIDTH)
			cols_reg = value;
		else
			rows_reg = value;
	endtask

	function automatic req_t make_req(logic [1:0] act, int x, int y, bit pass,
			int slow, int gx, int gy);
		req_t r;
		r.action = act;
		r.cell_x = coord_t'(x);
		r.cell_y = coord_t'(y);
		r.passable = pass;
		r.slow_factor = 8'(slow);
		r.goal_x = coord_t'(gx);
		r.goal_y = coord_t'(gy);
		return r;
	endfunction

	task automatic issue(input req_t r);
		rsp_t p;
		send_beat(r, p);
	endtask

	task automatic read_back(input int extra);
		rsp_t p;
		int   n;
		n = 0;
		do begin
			send_beat(make_req(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 63),
				$urandom_range(0, 63)), p);
			n++;
		end while (!p.last && n < 200);
		repeat (extra) issue(make_req(ACT_READ, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_directed();
		write_size(ADDR_WIDTH, 7'd64);
		write_size(ADDR_HEIGHT, 7'd64);
		issue(make_req(ACT_READ, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_NONE, 63, 63, 1, 255, 63, 63));
		issue(make_req(ACT_LOAD, 63, 63, 1, 255, 63, 63));
		issue(make_req(ACT_LOAD, 0, 0, 1, 0, 0, 0));
		issue(make_req(ACT_LOAD, 1, 1, 1, 16, 0, 0));
		issue(make_req(ACT_LOAD, 1, 0, 0, 170, 0, 0));
		issue(make_req(ACT_LOAD, 0, 1, 1, 1, 0, 0));
		// diagonal blocked by the impassable corner
		issue(make_req(ACT_SEARCH, 0, 0, 0, 0, 1, 1));
		read_back(1);
		// goal cut off from the start
		issue(make_req(ACT_SEARCH, 0, 0, 0, 0, 63, 63));
		read_back(0);
		write_size(ADDR_WIDTH, 7'd2);
		write_size(ADDR_HEIGHT, 7'd2);
		// start saturated into the map, goal outside it
		issue(make_req(ACT_SEARCH, 40, 40, 0, 0, 5, 5));
		read_back(0);
		// start on an impassable cell
		issue(make_req(ACT_SEARCH, 1, 0, 0, 0, 0, 0));
		read_back(0);
		// goal equals start
		issue(make_req(ACT_SEARCH, 0, 0, 0, 0, 0, 0));
		read_back(0);
		write_size(ADDR_WIDTH, 7'd1);
		write_size(ADDR_HEIGHT, 7'd1);
		issue(make_req(ACT_SEARCH, 5, 5, 0, 0, 0, 0));
		read_back(0);
	endtask

	function automatic int pick_coord(int span);
		return $urandom_range(0, 99) < 88 ? $urandom_range(0, span - 1) : $urandom_range(0, 63);
	endfunction

	task automatic run_phase();
		int   span;
		int   loads;
		int   searches;
		req_t r;
		if ($urandom_range(0, 9) == 0)
			write_size(ADDR_WIDTH, 7'($urandom_range(0, 127)));
		else
			write_size(ADDR_WIDTH, 7'($urandom_range(1, 12)));
		if ($urandom_range(0, 9) == 0)
			write_size(ADDR_HEIGHT, 7'($urandom_range(0, 127)));
		else
			write_size(ADDR_HEIGHT, 7'($urandom_range(1, 12)));
		span = 12;
		loads = $urandom_range(8, 30);
		repeat (loads) begin
			r = make_req(ACT_LOAD, pick_coord(span), pick_coord(span),
				$urandom_range(0, 99) < 75, $urandom_range(0, 255),
				$urandom_range(0, 63), $urandom_range(0, 63));
			if ($urandom_range(0, 19) == 0)
				r.action = ACT_NONE;
			issue(r);
		end
		searches = $urandom_range(1, 2);
		repeat (searches) begin
			issue(make_req(ACT_SEARCH, pick_coord(span), pick_coord(span),
				$urandom_range(0, 1), $urandom_range(0, 255),
				pick_coord(span), pick_coord(span)));
			read_back($urandom_range(0, 2));
		end
	endtask

	task automatic test_random();
		int phase;
		phase = 0;
		while (beats < ITEM_GOAL) begin
			calm = phase >= 6 && phase < 12;
			run_phase();
			phase++;
		end
		calm = 0;
	endtask

	task automatic test_drain_pause();
		issue(make_req(ACT_LOAD, 2, 2, 1, 32, 0, 0));
		issue(make_req(ACT_SEARCH, 2, 2, 0, 0, 0, 0));
		wait_drained();
		read_back(1);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		req <= '0;
		cols_reg = 7'd64;
		rows_reg = 7'd64;
		foreach (cell_mem[i])
			cell_mem[i] = '0;
		open_count = 0;
		nearest_idx = 0;
		nearest_h = 0;
		trace_idx = 0;
		trace_ok = 0;
		origin_idx = 0;
		exp_wr = 0;
		exp_rd = 0;
		fails = 0;
		cycles = 0;
		beats = 0;
		calm = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_drain_pause();
		test_random();
		start <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
